/* rtl/sct_pkg.sv */
package sct_pkg;

  localparam int NEURONS_DEF         = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int CHANNELS            = 3;
  localparam int CH_W                = 16;
  localparam int WORD_W              = CHANNELS * CH_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRAIN = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEURON_COUNT = 2'd0,
    CFG_TOTAL_STEPS  = 2'd1,
    CFG_INITIAL_RATE = 2'd2,
    CFG_SECOND_RATE  = 2'd3
  } cfg_idx_t;

  localparam logic [4:0]  NEURON_COUNT_RST = 5'd16;
  localparam logic [23:0] TOTAL_STEPS_RST  = 24'd65536;
  localparam logic [15:0] INITIAL_RATE_RST = 16'd62259;
  localparam logic [15:0] SECOND_RATE_RST  = 16'd6554;
  localparam logic [15:0] RADIUS_RST       = 16'((16 / 2) * 256);

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  neuron_index;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [15:0] load_red;
    logic [15:0] load_green;
    logic [15:0] load_blue;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  winner_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [23:0] steps_done;
    logic        training_over;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_SRCH_RD,
    ST_SRCH_LAT,
    ST_SRCH_DIST,
    ST_SRCH_CMP,
    ST_UPD_PREP,
    ST_UPD_RD,
    ST_UPD_LAT,
    ST_UPD_DIST,
    ST_UPD_CHK,
    ST_DIV_WAIT,
    ST_EXP_IDX,
    ST_EXP_INT,
    ST_GAIN,
    ST_MOVE,
    ST_UPD_WR,
    ST_RATE_START,
    ST_RATE_MUL,
    ST_RAD_WAIT,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // exp table entry k: k-fold truncated product of the Q0.32 step ratio, returned as Q0.16 saturated at 0xFFFF
  function automatic logic [15:0] exp_entry(input logic [63:0] ratio, input int k);
    logic [63:0] v;
    logic [63:0] e;
    v = 64'h1_0000_0000;
    for (int j = 0; j < k; j++) begin
      v = (v * ratio) >> 32;
    end
    e = v >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

/* rtl/sct_div.sv */
module sct_div #(
  parameter int DW = 58,
  parameter int VW = 36,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CNW = $clog2(QW + 1);

  // restoring divide, one quotient bit per cycle; needs dividend < divisor << QW
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]  div_r, div_nxt;
  logic [QW-1:0]  lo_r, lo_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [VW:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, lo_r[QW-1]};
    if (start) begin
      rem_nxt  = VW'(dividend >> QW);
      lo_nxt   = dividend[QW-1:0];
      div_nxt  = divisor;
      cnt_nxt  = CNW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = VW'(trial - {1'b0, div_r});
        lo_nxt  = {lo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        lo_nxt  = {lo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    lo_r  <= lo_nxt;
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule

/* rtl/som_color_trainer.sv */
// som_color_trainer: trains a self-organizing map of RGB colors.
//
// Input channel (in_valid / in_stall / in_data) carries load, train and read
// items; a transfer happens on a clock edge with valid high and stall low.
// Each item gives exactly one result on the out_ channel (out_valid /
// out_stall / out_data), held steady while the receiver stalls.
// Configuration: cfg_we with cfg_index / cfg_data, one write per cycle; the
// user must write only while the block is idle (the block does not enforce it).
//
// One item at a time; in_stall is low only when the sequencer is idle, and
// a finished result waits in the output register without blocking the next
// input transfer. A train item searches all neurons in use for the best match,
// then moves those inside the neighborhood and updates rate and radius.
// The weight memory port (one read, one write per cycle) and the bit-serial
// divider set the time each item takes.
// Reset (synchronous, rst_n low) clears step count and restores registers;
// weights are undefined until loaded.
module som_color_trainer
  import sct_pkg::*;
#(
  parameter int NEURONS         = NEURONS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(NEURONS);
  localparam int LD   = $clog2(EXP_TABLE_DEPTH);
  localparam int TIW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int QW   = LD + 16;
  localparam int D2W  = 34;
  localparam int NUMW = D2W + LD;
  localparam int DW   = NUMW + 16;
  localparam int VW   = 36;
  localparam logic [1:0] CH_LAST = 2'(CHANNELS - 1);

  // series for r = exp(-8/DEPTH), ten truncated terms
  localparam logic [63:0] ONE  = 64'h1_0000_0000;
  localparam logic [63:0] DEP  = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] TM1  = ONE * 64'd8 / (DEP * 64'd1);
  localparam logic [63:0] TM2  = TM1 * 64'd8 / (DEP * 64'd2);
  localparam logic [63:0] TM3  = TM2 * 64'd8 / (DEP * 64'd3);
  localparam logic [63:0] TM4  = TM3 * 64'd8 / (DEP * 64'd4);
  localparam logic [63:0] TM5  = TM4 * 64'd8 / (DEP * 64'd5);
  localparam logic [63:0] TM6  = TM5 * 64'd8 / (DEP * 64'd6);
  localparam logic [63:0] TM7  = TM6 * 64'd8 / (DEP * 64'd7);
  localparam logic [63:0] TM8  = TM7 * 64'd8 / (DEP * 64'd8);
  localparam logic [63:0] TM9  = TM8 * 64'd8 / (DEP * 64'd9);
  localparam logic [63:0] TM10 = TM9 * 64'd8 / (DEP * 64'd10);
  localparam logic [63:0] EXP_RATIO = ONE - TM1 + TM2 - TM3 + TM4 - TM5
                                      + TM6 - TM7 + TM8 - TM9 + TM10;

  function automatic logic [15:0] chan_get(input logic [WORD_W-1:0] w, input logic [1:0] c);
    case (c)
      2'd0:    return w[47:32];
      2'd1:    return w[31:16];
      default: return w[15:0];
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] chan_set(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] c, input logic [15:0] v);
    logic [WORD_W-1:0] r;
    r = w;
    case (c)
      2'd0:    r[47:32] = v;
      2'd1:    r[31:16] = v;
      default: r[15:0]  = v;
    endcase
    return r;
  endfunction

  function automatic logic [AW:0] clamp_n(input logic [4:0] c);
    if (c == 5'd0) return (AW+1)'(1);
    else if (32'(c) > NEURONS) return (AW+1)'(NEURONS);
    else return (AW+1)'(c);
  endfunction

  // exp table, constant logic
  logic [15:0] exp_tab [EXP_TABLE_DEPTH+1];
  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    assign exp_tab[k] = exp_entry(EXP_RATIO, k);
  end

  // weight memory, {red, green, blue}
  logic [WORD_W-1:0] mem [NEURONS];
  logic [WORD_W-1:0] mem_q_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic [QW-1:0] div_q;

  sct_div #(.DW(DW), .VW(VW), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  logic [1:0]        c_r, c_nxt;
  logic [AW:0]       n_r, n_nxt;
  logic [D2W-1:0]    acc_r, acc_nxt;
  logic [D2W-1:0]    best_r, best_nxt;
  logic [AW-1:0]     bmu_r, bmu_nxt;
  logic [WORD_W-1:0] wb_r, wb_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] w_r, w_nxt;
  logic [31:0]       rlim_r, rlim_nxt;
  logic [31:0]       den_r, den_nxt;
  logic [15:0]       h_r, h_nxt;
  logic [15:0]       g_r, g_nxt;
  logic [15:0]       hi_r, hi_nxt;
  logic [15:0]       diff_r, diff_nxt;
  logic [15:0]       frac_r, frac_nxt;
  logic              zero_r, zero_nxt;
  logic              exp_rate_r, exp_rate_nxt;
  logic [4:0]        ncount_r, ncount_nxt;
  logic [23:0]       tsteps_r, tsteps_nxt;
  logic [15:0]       irate_r, irate_nxt;
  logic [15:0]       srate_r, srate_nxt;
  logic [23:0]       step_r, step_nxt;
  logic [23:0]       pstart_r, pstart_nxt;
  logic [15:0]       rate_r, rate_nxt;
  logic [15:0]       prate_r, prate_nxt;
  logic [15:0]       radius_r, radius_nxt;

  // combinational helpers
  logic [AW+3:0]     idx_w;
  logic              idx_ok;
  logic              last_n;
  logic [WORD_W-1:0] dist_a;
  logic [16:0]       dsub;
  logic [33:0]       dsq;
  logic [NUMW-1:0]   num;
  logic [VW-1:0]     vsr;
  logic [LD:0]       eidx, eidx1;
  logic [15:0]       xc, wc, mag, stp;
  logic [31:0]       mprod;
  logic [23:0]       tdiff;
  logic [35:0]       rad_num;
  logic [26:0]       t5;
  logic [23:0]       step_inc;
  logic [23:0]       rd_r, rd_g, rd_b;

  assign idx_w  = (AW+4)'(item_r.neuron_index);
  assign idx_ok = idx_w < (AW+4)'(NEURONS);
  assign last_n = ({1'b0, i_r} == (n_r - 1'b1));
  assign dist_a = (state_r == ST_SRCH_DIST) ? x_r : wb_r;
  assign dsub   = {1'b0, chan_get(dist_a, c_r)} - {1'b0, chan_get(w_r, c_r)};
  assign dsq    = 34'($signed(dsub) * $signed(dsub));
  assign eidx   = {1'b0, div_q[QW-1:16]};
  assign eidx1  = eidx + 1'b1;
  assign xc     = chan_get(x_r, c_r);
  assign wc     = chan_get(w_r, c_r);
  assign mag    = (xc >= wc) ? (xc - wc) : (wc - xc);
  assign mprod  = g_r * mag;
  assign stp    = mprod[31:16];
  assign tdiff  = tsteps_r - step_r;
  assign rad_num = 36'(4'(n_r >> 1)) * 36'({tdiff, 8'h00});
  assign t5     = 27'(step_r) * 27'd5;
  assign step_inc = step_r + 1'b1;
  // floor(w * 255 / 65536), times 255 as shift and subtract
  assign rd_r   = {mem_q_r[47:32], 8'h00} - 24'(mem_q_r[47:32]);
  assign rd_g   = {mem_q_r[31:16], 8'h00} - 24'(mem_q_r[31:16]);
  assign rd_b   = {mem_q_r[15:0], 8'h00} - 24'(mem_q_r[15:0]);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    i_nxt         = i_r;
    c_nxt         = c_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    bmu_nxt       = bmu_r;
    wb_nxt        = wb_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    rlim_nxt      = rlim_r;
    den_nxt       = den_r;
    h_nxt         = h_r;
    g_nxt         = g_r;
    hi_nxt        = hi_r;
    diff_nxt      = diff_r;
    frac_nxt      = frac_r;
    zero_nxt      = zero_r;
    exp_rate_nxt  = exp_rate_r;
    ncount_nxt    = ncount_r;
    tsteps_nxt    = tsteps_r;
    irate_nxt     = irate_r;
    srate_nxt     = srate_r;
    step_nxt      = step_r;
    pstart_nxt    = pstart_r;
    rate_nxt      = rate_r;
    prate_nxt     = prate_r;
    radius_nxt    = radius_r;
    mem_we        = 1'b0;
    mem_waddr     = i_r;
    mem_wdata     = w_r;
    mem_raddr     = i_r;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    num           = '0;
    vsr           = '0;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_nxt               = '0;
        res_nxt.steps_done    = step_r;
        res_nxt.training_over = (step_r >= tsteps_r);
        mem_raddr             = idx_w[AW-1:0];
        case (op_t'(item_r.operation))
          OP_LOAD: begin
            mem_we    = idx_ok;
            mem_waddr = idx_w[AW-1:0];
            mem_wdata = {item_r.load_red, item_r.load_green, item_r.load_blue};
            state_nxt = ST_OUTPUT;
          end
          OP_READ: begin
            state_nxt = ST_READ_WAIT;
          end
          OP_TRAIN: begin
            if (step_r >= tsteps_r) begin
              state_nxt = ST_OUTPUT;
            end else begin
              x_nxt = {item_r.pixel_red, item_r.pixel_red,
                       item_r.pixel_green, item_r.pixel_green,
                       item_r.pixel_blue, item_r.pixel_blue};
              n_nxt     = clamp_n(ncount_r);
              i_nxt     = '0;
              state_nxt = ST_SRCH_RD;
            end
          end
          default: begin
            state_nxt = ST_OUTPUT;
          end
        endcase
      end

      ST_READ_WAIT: begin
        if (idx_ok) begin
          res_nxt.out_red   = rd_r[23:16];
          res_nxt.out_green = rd_g[23:16];
          res_nxt.out_blue  = rd_b[23:16];
        end
        state_nxt = ST_OUTPUT;
      end

      // best matching unit search
      ST_SRCH_RD: begin
        state_nxt = ST_SRCH_LAT;
      end

      ST_SRCH_LAT: begin
        w_nxt     = mem_q_r;
        acc_nxt   = '0;
        c_nxt     = '0;
        state_nxt = ST_SRCH_DIST;
      end

      ST_SRCH_DIST: begin
        acc_nxt = acc_r + dsq;
        c_nxt   = c_r + 1'b1;
        if (c_r == CH_LAST) state_nxt = ST_SRCH_CMP;
      end

      ST_SRCH_CMP: begin
        // strict less-than keeps the lower index on ties
        if (i_r == '0 || acc_r < best_r) begin
          best_nxt = acc_r;
          bmu_nxt  = i_r;
          wb_nxt   = w_r;
        end
        if (last_n) begin
          state_nxt = ST_UPD_PREP;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end

      // neighborhood update
      ST_UPD_PREP: begin
        rlim_nxt = radius_r * radius_r;
        den_nxt  = rate_r * rate_r;
        i_nxt    = '0;
        state_nxt = (rate_r == '0) ? ST_RATE_START : ST_UPD_RD;
      end

      ST_UPD_RD: begin
        state_nxt = ST_UPD_LAT;
      end

      ST_UPD_LAT: begin
        w_nxt     = mem_q_r;
        acc_nxt   = '0;
        c_nxt     = '0;
        state_nxt = ST_UPD_DIST;
      end

      ST_UPD_DIST: begin
        acc_nxt = acc_r + dsq;
        c_nxt   = c_r + 1'b1;
        if (c_r == CH_LAST) state_nxt = ST_UPD_CHK;
      end

      ST_UPD_CHK: begin
        // d2 < radius^2 * 2^16 compared on d2 >> 16
        if (32'(acc_r[D2W-1:16]) >= rlim_r) begin
          if (last_n) begin
            state_nxt = ST_RATE_START;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_UPD_RD;
          end
        end else begin
          num = NUMW'(acc_r) * NUMW'(EXP_TABLE_DEPTH);
          vsr = {den_r, 4'h0};
          if ({2'b00, num} < ((NUMW+2)'(vsr) << LD)) begin
            div_start    = 1'b1;
            div_dividend = {num, 16'h0000};
            div_divisor  = vsr;
            exp_rate_nxt = 1'b0;
            state_nxt    = ST_DIV_WAIT;
          end else begin
            h_nxt     = '0;
            state_nxt = ST_GAIN;
          end
        end
      end

      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_EXP_IDX;
      end

      ST_EXP_IDX: begin
        zero_nxt  = (32'(eidx) >= EXP_TABLE_DEPTH);
        hi_nxt    = exp_tab[eidx[TIW-1:0]];
        diff_nxt  = exp_tab[eidx[TIW-1:0]] - exp_tab[eidx1[TIW-1:0]];
        frac_nxt  = div_q[15:0];
        state_nxt = ST_EXP_INT;
      end

      ST_EXP_INT: begin
        mprod_int_blk: begin
          logic [31:0] ip;
          ip    = diff_r * frac_r;
          h_nxt = zero_r ? 16'h0000 : (hi_r - ip[31:16]);
        end
        state_nxt = exp_rate_r ? ST_RATE_MUL : ST_GAIN;
      end

      ST_GAIN: begin
        gain_blk: begin
          logic [31:0] gp;
          gp    = rate_r * h_r;
          g_nxt = gp[31:16];
        end
        c_nxt     = '0;
        state_nxt = ST_MOVE;
      end

      ST_MOVE: begin
        w_nxt = chan_set(w_r, c_r, (xc >= wc) ? (wc + stp) : (wc - stp));
        c_nxt = c_r + 1'b1;
        if (c_r == CH_LAST) state_nxt = ST_UPD_WR;
      end

      ST_UPD_WR: begin
        mem_we = 1'b1;
        // later neurons measure against the BMU as already moved
        if (i_r == bmu_r) wb_nxt = w_r;
        if (last_n) begin
          state_nxt = ST_RATE_START;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_UPD_RD;
        end
      end

      // rate and radius schedule
      ST_RATE_START: begin
        num = NUMW'(step_r - pstart_r) * NUMW'(EXP_TABLE_DEPTH);
        vsr = VW'({tsteps_r, 3'b000});
        if ({2'b00, num} < ((NUMW+2)'(vsr) << LD)) begin
          div_start    = 1'b1;
          div_dividend = {num, 16'h0000};
          div_divisor  = vsr;
          exp_rate_nxt = 1'b1;
          state_nxt    = ST_DIV_WAIT;
        end else begin
          h_nxt     = '0;
          state_nxt = ST_RATE_MUL;
        end
      end

      ST_RATE_MUL: begin
        rate_blk: begin
          logic [31:0] rp;
          rp       = prate_r * h_r;
          rate_nxt = rp[31:16];
        end
        div_start    = 1'b1;
        div_dividend = DW'(rad_num) << LD;
        div_divisor  = VW'(tsteps_r);
        state_nxt    = ST_RAD_WAIT;
      end

      ST_RAD_WAIT: begin
        if (div_done) begin
          radius_nxt = div_q[LD+15:LD];
          state_nxt  = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // step equals floor(T/5)
        if (t5 <= 27'(tsteps_r) && 27'(tsteps_r) < t5 + 27'd5) begin
          rate_nxt   = srate_r;
          prate_nxt  = srate_r;
          pstart_nxt = step_r;
        end
        step_nxt              = step_inc;
        res_nxt.winner_index  = 4'(bmu_r);
        res_nxt.steps_done    = step_inc;
        res_nxt.training_over = (step_inc >= tsteps_r);
        state_nxt             = ST_OUTPUT;
      end

      ST_OUTPUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NEURON_COUNT: begin
          ncount_nxt = cfg_data[4:0];
          if (step_r == '0) radius_nxt = 16'(clamp_n(cfg_data[4:0]) >> 1) << 8;
        end
        CFG_TOTAL_STEPS: begin
          tsteps_nxt = cfg_data[23:0];
        end
        CFG_INITIAL_RATE: begin
          irate_nxt = cfg_data[15:0];
          if (step_r == '0) begin
            rate_nxt  = cfg_data[15:0];
            prate_nxt = cfg_data[15:0];
          end
        end
        CFG_SECOND_RATE: begin
          srate_nxt = cfg_data[15:0];
        end
        default: begin
          srate_nxt = srate_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ncount_r    <= NEURON_COUNT_RST;
      tsteps_r    <= TOTAL_STEPS_RST;
      irate_r     <= INITIAL_RATE_RST;
      srate_r     <= SECOND_RATE_RST;
      step_r      <= '0;
      pstart_r    <= '0;
      rate_r      <= INITIAL_RATE_RST;
      prate_r     <= INITIAL_RATE_RST;
      radius_r    <= RADIUS_RST;
      exp_rate_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ncount_r    <= ncount_nxt;
      tsteps_r    <= tsteps_nxt;
      irate_r     <= irate_nxt;
      srate_r     <= srate_nxt;
      step_r      <= step_nxt;
      pstart_r    <= pstart_nxt;
      rate_r      <= rate_nxt;
      prate_r     <= prate_nxt;
      radius_r    <= radius_nxt;
      exp_rate_r  <= exp_rate_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    i_r    <= i_nxt;
    c_r    <= c_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    best_r <= best_nxt;
    bmu_r  <= bmu_nxt;
    wb_r   <= wb_nxt;
    x_r    <= x_nxt;
    w_r    <= w_nxt;
    rlim_r <= rlim_nxt;
    den_r  <= den_nxt;
    h_r    <= h_nxt;
    g_r    <= g_nxt;
    hi_r   <= hi_nxt;
    diff_r <= diff_nxt;
    frac_r <= frac_nxt;
    zero_r <= zero_nxt;
  end

endmodule

/* test/som_color_trainer_tb.sv */
`timescale 1ns / 100ps

module som_color_trainer_tb
  import sct_pkg::*;
;

  localparam int  TBL_DEPTH   = EXP_TABLE_DEPTH_DEF;
  localparam int  MAX_NEURONS = NEURONS_DEF;
  // Whole-run limit, sized from the slowest train (all neurons in the neighborhood)
  // plus stall waits and sender gaps, then taken several times over.
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int  SETTLE      = 60;

  // ---------------------------------------------------------------------------
  // SOM scoreboard: mirrors codebook, schedule state and registers, predicts
  // one result per accepted transfer and checks results in order.
  // ---------------------------------------------------------------------------
  class som_scoreboard;
    bit [15:0]       codebook[MAX_NEURONS][CHANNELS];
    longint unsigned exp_tbl[TBL_DEPTH+1];
    longint unsigned step_count, phase_origin, rate_now, rate_phase, radius_q;
    longint unsigned n_count, t_total, rate_first, rate_second;
    out_item_t       expected_q[$];
    int              mismatches;

    function new();
      longint unsigned term, sum, v, e;
      term = 64'h1_0000_0000;
      sum  = 64'h1_0000_0000;
      v    = 64'h1_0000_0000;
      for (longint unsigned k = 1; k <= 10; k++) begin
        term = term * 8 / (TBL_DEPTH * k);
        if (k & 1) sum -= term;
        else sum += term;
      end
      for (int k = 0; k <= TBL_DEPTH; k++) begin
        e = v >> 16;
        exp_tbl[k] = (e > 65535) ? 65535 : e;
        v = (v * sum) >> 32;
      end
      n_count = NEURON_COUNT_RST; t_total = TOTAL_STEPS_RST;
      rate_first = INITIAL_RATE_RST; rate_second = SECOND_RATE_RST;
      step_count = 0; phase_origin = 0;
      rate_now = rate_first; rate_phase = rate_first;
      radius_q = RADIUS_RST;
      mismatches = 0;
    endfunction

    // exp(-y), table position y*DEPTH/8 = num/den
    function longint unsigned exp_neg(longint unsigned num, longint unsigned den);
      longint unsigned idx, frac, hi, lo;
      idx = num / den;
      if (idx >= TBL_DEPTH) return 0;
      frac = ((num - idx * den) << 16) / den;
      hi = exp_tbl[idx];
      lo = exp_tbl[idx+1];
      return hi - (((hi - lo) * frac) >> 16);
    endfunction

    function longint unsigned active_neurons();
      if (n_count < 1) return 1;
      if (n_count > MAX_NEURONS) return MAX_NEURONS;
      return n_count;
    endfunction

    function longint unsigned sq_dist(longint a0, longint a1, longint a2, int j);
      longint d0, d1, d2;
      d0 = a0 - longint'(codebook[j][0]);
      d1 = a1 - longint'(codebook[j][1]);
      d2 = a2 - longint'(codebook[j][2]);
      return d0*d0 + d1*d1 + d2*d2;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [23:0] val);
      case (idx)
        CFG_NEURON_COUNT: begin
          n_count = val[4:0];
          if (step_count == 0) radius_q = (active_neurons() / 2) * 256;
        end
        CFG_TOTAL_STEPS: t_total = val;
        CFG_INITIAL_RATE: begin
          rate_first = val[15:0];
          if (step_count == 0) begin
            rate_now = rate_first;
            rate_phase = rate_first;
          end
        end
        default: rate_second = val[15:0];
      endcase
    endfunction

    // one SOM step; returns winning neuron
    function int train_pixel(longint px0, longint px1, longint px2);
      longint unsigned n, best, d, lim, h, gain, t, e;
      longint wb0, wb1, wb2, w, diff, mag, delta, px[3];
      int bmu;
      px[0] = px0; px[1] = px1; px[2] = px2;
      n = active_neurons();
      bmu = 0;
      best = sq_dist(px0, px1, px2, 0);
      for (int j = 1; j < n; j++) begin
        d = sq_dist(px0, px1, px2, j);
        if (d < best) begin
          best = d;
          bmu = j;
        end
      end
      lim = (radius_q * radius_q) << 16;
      for (int j = 0; j < n && rate_now != 0; j++) begin
        // winner weights as already moved this step
        wb0 = codebook[bmu][0]; wb1 = codebook[bmu][1]; wb2 = codebook[bmu][2];
        d = sq_dist(wb0, wb1, wb2, j);
        if (d >= lim) continue;
        h = exp_neg(d * TBL_DEPTH, 16 * rate_now * rate_now);
        gain = (rate_now * h) >> 16;
        for (int c = 0; c < CHANNELS; c++) begin
          w = codebook[j][c];
          diff = px[c] - w;
          mag = (diff < 0) ? -diff : diff;
          delta = longint'((gain * mag) >> 16);
          w += (diff < 0) ? -delta : delta;
          codebook[j][c] = w[15:0];
        end
      end
      t = step_count;
      e = exp_neg((t - phase_origin) * TBL_DEPTH, 8 * t_total);
      rate_now = (rate_phase * e) >> 16;
      radius_q = (n / 2) * 256 * (t_total - t) / t_total;
      if (t == t_total / 5) begin
        rate_now = rate_second;
        rate_phase = rate_second;
        phase_origin = t;
      end
      step_count++;
      return bmu;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      r = '0;
      case (op_t'(it.operation))
        OP_LOAD: begin
          codebook[it.neuron_index][0] = it.load_red;
          codebook[it.neuron_index][1] = it.load_green;
          codebook[it.neuron_index][2] = it.load_blue;
        end
        OP_TRAIN: begin
          if (step_count < t_total)
            r.winner_index = 4'(train_pixel(it.pixel_red * 257, it.pixel_green * 257,
                                            it.pixel_blue * 257));
        end
        OP_READ: begin
          r.out_red   = 8'((32'(codebook[it.neuron_index][0]) * 255) >> 16);
          r.out_green = 8'((32'(codebook[it.neuron_index][1]) * 255) >> 16);
          r.out_blue  = 8'((32'(codebook[it.neuron_index][2]) * 255) >> 16);
        end
        default: ;
      endcase
      r.steps_done = step_count[23:0];
      r.training_over = (step_count >= t_total);
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.winner_index !== want.winner_index || got.out_red !== want.out_red ||
          got.out_green !== want.out_green || got.out_blue !== want.out_blue ||
          got.steps_done !== want.steps_done || got.training_over !== want.training_over)
      begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  som_scoreboard som_sb = new();
  longint cycles = 0;
  int     burst_left = 0;
  int     stall_mode = 0;

  som_color_trainer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result transfers go straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) som_sb.check_result(out_data);
  end

  // receiver back-pressure: a randomly chosen stall mode; mode 0 never stalls
  always @(negedge clk) begin
    if (cycles[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= cycles[3];
    endcase
  end

  // one input transfer, sender idles between bursts
  task automatic send_item(in_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    som_sb.note_input(it);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic load_neuron(int j, bit [15:0] r, bit [15:0] g, bit [15:0] b);
    in_item_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.neuron_index = 4'(j);
    it.load_red = r; it.load_green = g; it.load_blue = b;
    send_item(it);
  endtask

  task automatic pixel_op(op_t op, int j, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.neuron_index = 4'(j);
    it.pixel_red = r; it.pixel_green = g; it.pixel_blue = b;
    send_item(it);
  endtask

  // mostly training, plus loads, reads and the odd unused opcode
  task automatic random_items(int count);
    in_item_t it;
    int pick;
    for (int k = 0; k < count; k++) begin
      it = in_item_t'({$urandom(), $urandom(), $urandom()});
      pick = $urandom_range(0, 99);
      if (pick < 60) it.operation = OP_TRAIN;
      else if (pick < 75) it.operation = OP_LOAD;
      else if (pick < 95) it.operation = OP_READ;
      else it.operation = OP_NONE;
      send_item(it);
    end
  endtask

  // block must be idle before a register write
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (som_sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // consecutive writes keep cfg_we high; caller lowers it afterwards
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[23:0];
    som_sb.write_reg(idx, val[23:0]);
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Setup before training: out-of-range count clamps, rate registers reload.
    // Short T so training runs out and the phase switch drops rate to zero.
    write_reg(CFG_NEURON_COUNT, 31);
    write_reg(CFG_INITIAL_RATE, 16'hFFFF);
    write_reg(CFG_SECOND_RATE, 0);
    write_reg(CFG_TOTAL_STEPS, 40);
    cfg_we <= 1'b0;
    @(negedge clk);

    // every neuron loaded first, so nothing unwritten is ever read or trained
    for (int j = 0; j < MAX_NEURONS; j++)
      load_neuron(j, 16'(j * 4369), 16'(j * 4369), 16'(j * 4369));
    load_neuron(0, 16'h0000, 16'hFFFF, 16'h0000);
    load_neuron(15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_neuron(6, 16'(3 * 4369), 16'(3 * 4369), 16'(3 * 4369));  // tie with 3
    pixel_op(OP_READ, 0, 0, 0, 0);
    pixel_op(OP_READ, 15, 0, 0, 0);
    pixel_op(OP_TRAIN, 0, 8'd51, 8'd51, 8'd51);  // tie: lower index wins
    pixel_op(OP_TRAIN, 0, 8'd0, 8'd0, 8'd0);
    pixel_op(OP_TRAIN, 0, 8'hFF, 8'hFF, 8'hFF);
    pixel_op(OP_TRAIN, 0, 8'hFF, 8'h00, 8'hAA);
    pixel_op(OP_NONE, 9, 8'hFF, 8'hFF, 8'hFF);
    pixel_op(OP_READ, 3, 0, 0, 0);
    pixel_op(OP_READ, 6, 0, 0, 0);
    random_items(150);
    drain();

    // Restart training: T chosen so the next step hits T/5 and switches to a
    // fresh rate. initial_rate now has no effect since steps were taken.
    write_reg(CFG_SECOND_RATE, 40000);
    write_reg(CFG_INITIAL_RATE, 0);
    write_reg(CFG_TOTAL_STEPS, 32'(5 * som_sb.step_count + 3));
    write_reg(CFG_NEURON_COUNT, 1);
    cfg_we <= 1'b0;
    random_items(150);
    drain();

    write_reg(CFG_NEURON_COUNT, 16);
    write_reg(CFG_SECOND_RATE, 16'hFFFF);
    write_reg(CFG_TOTAL_STEPS, 32'(5 * som_sb.step_count + 1));
    cfg_we <= 1'b0;
    random_items(200);
    drain();

    // count 0 acts as one neuron; longest training length
    write_reg(CFG_NEURON_COUNT, 0);
    write_reg(CFG_TOTAL_STEPS, 24'hFFFFFF);
    cfg_we <= 1'b0;
    random_items(100);
    drain();

    write_reg(CFG_NEURON_COUNT, 9);
    write_reg(CFG_SECOND_RATE, 1);
    write_reg(CFG_TOTAL_STEPS, 32'(5 * som_sb.step_count + 4));
    cfg_we <= 1'b0;
    random_items(150);
    drain();

    if (som_sb.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
